// File: hw/rtl/mtf_pkg.sv
// Shared constants and types of the move-to-front list.
// Used by move_to_front_list and its port checker; depends on nothing.

package mtf_pkg;

    // list size and derived widths
    localparam int DEPTH  = 16;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int VAL_W  = 32;

    // result fields
    localparam int POS_W     = 4;
    localparam int ENT_W     = 5;
    localparam int STAT_W    = 2;
    localparam int M_TDATA_W = 16;

    // request kinds carried on the slave tuser
    localparam logic MODE_PUSH   = 1'b0;
    localparam logic MODE_SEARCH = 1'b1;

    // result status codes carried on the master tuser
    typedef enum logic [STAT_W-1:0] {
        ST_PUSHED    = 2'd0,
        ST_FOUND     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

endpackage

// File: hw/rtl/move_to_front_list.sv
// Move-to-front list: sequencer, entry memory and output register.
// Depends on mtf_pkg for sizes and status codes.

// The entry memory has a read and a write port and a registered read; each entry
// visited is read, then compared or written back one place. A push moves every
// entry back, then writes the front; a search reads from the front until it hits,
// moves the entries ahead of the hit back and writes the front; a miss reads every
// entry; a full push or a search of an empty list goes straight to the result. One
// request is worked at a time; s_tready is high only while the sequencer is idle,
// and a finished result waits in the output register, so the next request may be
// accepted before the previous result is taken. No clearing pass after reset.
module move_to_front_list (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request channel
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [mtf_pkg::VAL_W-1:0]     s_tdata,   // [31:0] value
    input  logic [0:0]                    s_tuser,   // [0] mode
    // result channel
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [mtf_pkg::M_TDATA_W-1:0] m_tdata,   // [3:0] position, [8:4] entry_count
    output logic [mtf_pkg::STAT_W-1:0]    m_tuser    // [1:0] status
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_SH_RD  = 7'b0000010,
        S_SH_WR  = 7'b0000100,
        S_SC_RD  = 7'b0001000,
        S_SC_CMP = 7'b0010000,
        S_FRONT  = 7'b0100000,
        S_DONE   = 7'b1000000
    } t_state;

    t_state                      r_state, n_state;
    logic [mtf_pkg::CNT_W-1:0]   r_count, n_count;
    logic [mtf_pkg::IDX_W-1:0]   r_idx, n_idx;
    logic                        r_mode, n_mode;
    logic [mtf_pkg::VAL_W-1:0]   r_val, n_val;
    mtf_pkg::t_status            r_status, n_status;
    logic [mtf_pkg::IDX_W-1:0]   r_pos, n_pos;

    logic                        r_out_valid;
    logic [mtf_pkg::M_TDATA_W-1:0] r_out_data;
    logic [mtf_pkg::STAT_W-1:0]  r_out_user;

    // entry memory
    logic [mtf_pkg::VAL_W-1:0]   mem [mtf_pkg::DEPTH];
    logic [mtf_pkg::VAL_W-1:0]   r_rd_data;
    logic [mtf_pkg::IDX_W-1:0]   rd_addr;
    logic                        we;
    logic [mtf_pkg::IDX_W-1:0]   wa;
    logic [mtf_pkg::VAL_W-1:0]   wd;

    logic                        s_fire;
    logic                        out_free;
    logic                        scan_last;
    logic [31:0]                 pos_ext;
    logic [31:0]                 cnt_ext;

    assign s_tready  = (r_state == S_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign out_free  = !r_out_valid || m_tready;
    assign scan_last = (mtf_pkg::CNT_W'(r_idx) + mtf_pkg::CNT_W'(1)) == r_count;
    assign pos_ext   = 32'(r_pos);
    assign cnt_ext   = 32'(r_count);

    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_out_data;
    assign m_tuser  = r_out_user;

    // memory port: one read address, one write address
    always_comb begin
        rd_addr = (r_state == S_SH_RD) ? r_idx - mtf_pkg::IDX_W'(1) : r_idx;
        we      = (r_state == S_SH_WR) || (r_state == S_FRONT);
        wa      = (r_state == S_FRONT) ? '0 : r_idx;
        wd      = (r_state == S_FRONT) ? r_val : r_rd_data;
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        r_rd_data <= mem[rd_addr];
    end

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_idx    = r_idx;
        n_mode   = r_mode;
        n_val    = r_val;
        n_status = r_status;
        n_pos    = r_pos;
        case (r_state)
            S_IDLE: begin
                if (s_fire) begin
                    n_mode = s_tuser[0];
                    n_val  = s_tdata;
                    n_pos  = '0;
                    if (s_tuser[0] == mtf_pkg::MODE_PUSH) begin
                        if (r_count == mtf_pkg::CNT_W'(mtf_pkg::DEPTH)) begin
                            n_status = mtf_pkg::ST_FULL;
                            n_state  = S_DONE;
                        end else begin
                            n_idx   = r_count[mtf_pkg::IDX_W-1:0];
                            n_state = (r_count == '0) ? S_FRONT : S_SH_RD;
                        end
                    end else begin
                        n_idx = '0;
                        if (r_count == '0) begin
                            n_status = mtf_pkg::ST_NOT_FOUND;
                            n_state  = S_DONE;
                        end else begin
                            n_state = S_SC_RD;
                        end
                    end
                end
            end
            S_SH_RD: begin
                n_state = S_SH_WR;
            end
            S_SH_WR: begin
                // entry k-1 has moved to k
                n_idx   = r_idx - mtf_pkg::IDX_W'(1);
                n_state = (r_idx == mtf_pkg::IDX_W'(1)) ? S_FRONT : S_SH_RD;
            end
            S_SC_RD: begin
                n_state = S_SC_CMP;
            end
            S_SC_CMP: begin
                if (r_rd_data == r_val) begin
                    n_pos   = r_idx;
                    n_state = (r_idx == '0) ? S_FRONT : S_SH_RD;
                end else if (scan_last) begin
                    n_status = mtf_pkg::ST_NOT_FOUND;
                    n_state  = S_DONE;
                end else begin
                    n_idx   = r_idx + mtf_pkg::IDX_W'(1);
                    n_state = S_SC_RD;
                end
            end
            S_FRONT: begin
                if (r_mode == mtf_pkg::MODE_PUSH) begin
                    n_count  = r_count + mtf_pkg::CNT_W'(1);
                    n_status = mtf_pkg::ST_PUSHED;
                end else begin
                    n_status = mtf_pkg::ST_FOUND;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control and working registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_idx    <= n_idx;
        r_mode   <= n_mode;
        r_val    <= n_val;
        r_status <= n_status;
        r_pos    <= n_pos;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_DONE) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_tready) begin
            r_out_valid <= 1'b0;
        end
        if ((r_state == S_DONE) && out_free) begin
            r_out_data <= mtf_pkg::M_TDATA_W'({cnt_ext[mtf_pkg::ENT_W-1:0],
                                               pos_ext[mtf_pkg::POS_W-1:0]});
            r_out_user <= r_status;
        end
    end

endmodule

// File: hw/rtl/mtf_checker.sv
// Port-level checker for move_to_front_list, attached by bind.
// Depends on mtf_pkg for status codes and sizes.

module mtf_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [mtf_pkg::VAL_W-1:0]     s_tdata,
    input logic [0:0]                    s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [mtf_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [mtf_pkg::STAT_W-1:0]    m_tuser
);

    logic [31:0] depth_ext;
    assign depth_ext = 32'(mtf_pkg::DEPTH);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // position is only reported for a hit
    a_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && (m_tuser != mtf_pkg::ST_FOUND) |-> (m_tdata[3:0] == 4'd0))
        else $error("position set on a result other than found");

    // a rejected push reports a full list
    a_full_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && (m_tuser == mtf_pkg::ST_FULL) |-> (m_tdata[8:4] == depth_ext[4:0]))
        else $error("full status with list not full");

    // the block is not ready in the cycle after a request is accepted
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("ready straight after a request");

endmodule

bind move_to_front_list mtf_checker u_mtf_checker (.*);
